// ===== src/bca_pkg.sv =====
// Package for the bitmap contiguous block allocator.
// Holds the request and response beat types, status and command codes and sizes.
// No dependencies.
package bca_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int WORD_W     = 32;
  localparam int NUM_WORDS  = NUM_BLOCKS / WORD_W;
  localparam int WORD_AW    = $clog2(NUM_WORDS);
  localparam int BIT_AW     = $clog2(WORD_W);
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int PADDR_W    = 3;

  localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = 11'd1024;
  localparam logic [CNT_W-1:0] BLOCK_COUNT_MAX   = 11'd1024;

  // Register byte addresses (word index in paddr[2]).
  localparam logic REG_BLOCK_COUNT = 1'b0;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic             command;
    logic [CNT_W-1:0] run_length;
    logic [IDX_W-1:0] block_index;
  } alloc_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] run_base;
    logic [CNT_W-1:0] free_count;
  } alloc_rsp_t;

endpackage

// ===== src/bitmap_contiguous_block_allocator_core.sv =====
// First-fit contiguous block allocator over a one-bit-per-block used map.
// Depends on bca_pkg for the beat types, codes and sizes.
//
//   Channel  Direction  Handshake               Payload
//   in       to block   in_valid / in_stall     alloc_req_t  (command, run_length, block_index)
//   out      from block out_valid / out_stall   alloc_rsp_t  (status, run_base, free_count)
//   cfg      to block   psel/penable/pwrite     block_count at byte address 0
//
// A free request or a zero-length allocate goes from accept straight to the done state.
// An allocate scans S used-map words (one 32-bit word per cycle through the single
// read port, at most 32) and on success marks M words (one per cycle through the
// write port) before it reaches the done state.
// Reset is synchronous and active high; the used map reads as all free right after
// reset, through one valid bit per map word, so there is no clearing pass.
// The block takes one request at a time. A stalled result waits in the output
// register, and the next request is accepted as soon as that result is loaded.
module bitmap_contiguous_block_allocator_core
  import bca_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  alloc_req_t         in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output alloc_rsp_t         out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MARK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // Returns {found, index} of the highest set bit of a map word.
  function automatic logic [BIT_AW:0] hi_set(input logic [WORD_W-1:0] v);
    logic [BIT_AW:0] r;
    r = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) r = {1'b1, BIT_AW'(i)};
    end
    return r;
  endfunction

  logic [1:0]         state;
  logic [CNT_W-1:0]   block_count;
  logic [CNT_W-1:0]   free_counter;
  logic [CNT_W-1:0]   req_len;
  logic [WORD_AW-1:0] w;
  logic [CNT_W-1:0]   run_start;
  logic [WORD_AW-1:0] mw;
  logic [WORD_AW-1:0] sw;
  logic [BIT_AW-1:0]  sb;
  logic [WORD_AW-1:0] ew;
  logic [BIT_AW-1:0]  eb;
  logic [1:0]         res_status;
  logic [IDX_W-1:0]   res_first;

  // Used map storage: one word per row, a valid bit per row stands for reset.
  logic [WORD_W-1:0]  mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_valid;
  logic [WORD_W-1:0]  rd_data;
  logic               rd_vld;
  logic [WORD_AW-1:0] rd_addr;
  logic               wr_en;
  logic [WORD_AW-1:0] wr_addr;
  logic [WORD_W-1:0]  wr_mask;
  logic [WORD_W-1:0]  wr_data;
  logic [WORD_W-1:0]  eff_mask;
  logic [WORD_W-1:0]  eff_data;

  logic               accept;
  logic               out_free;
  logic               cfg_wr;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_m1;
  logic [WORD_AW-1:0] last_word;

  // Scan unit signals.
  logic [WORD_W-1:0]  d;
  logic [CNT_W-1:0]   start_j [WORD_W];
  logic [WORD_W-1:0]  hit;
  logic               any_hit;
  logic [BIT_AW-1:0]  sel;
  logic [CNT_W-1:0]   sel_start;
  logic [CNT_W-1:0]   next_start;
  logic [BIT_AW:0]    word_hi;

  // Mark unit signals.
  logic [WORD_W-1:0]  mark_mask;
  logic [BIT_AW-1:0]  mark_lo;
  logic [BIT_AW-1:0]  mark_hi;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_BLOCK_COUNT);
  assign prdata   = (paddr[2] == REG_BLOCK_COUNT) ? 32'(block_count) : 32'd0;

  // Effective block count is the register clamped to 1..NUM_BLOCKS.
  always_comb begin
    if (block_count == '0) begin
      cnt = CNT_W'(1);
    end else if (block_count > BLOCK_COUNT_MAX) begin
      cnt = BLOCK_COUNT_MAX;
    end else begin
      cnt = block_count;
    end
  end
  assign cnt_m1    = cnt - CNT_W'(1);
  assign last_word = cnt_m1[IDX_W-1:BIT_AW];

  // Scan of one map word: for each bit, the run of free blocks ending there is
  // measured from its start, which is the bit after the last used one, either in
  // this word or carried in from earlier words. The lowest bit whose run reaches
  // the requested length ends the first fitting run.
  assign d = rd_vld ? rd_data : '0;

  always_comb begin
    logic [BIT_AW:0]    hp;
    logic [IDX_W-1:0]   g;
    logic [CNT_W-1:0]   run;
    logic [WORD_W-1:0]  le_mask;
    for (int j = 0; j < WORD_W; j++) begin
      le_mask = {WORD_W{1'b1}} >> (WORD_W - 1 - j);
      hp  = hi_set(d & le_mask);
      g   = {w, BIT_AW'(j)};
      if (hp[BIT_AW]) begin
        start_j[j] = CNT_W'({w, hp[BIT_AW-1:0]}) + CNT_W'(1);
      end else begin
        start_j[j] = run_start;
      end
      run    = CNT_W'(g) + CNT_W'(1) - start_j[j];
      hit[j] = (g <= cnt_m1[IDX_W-1:0]) && (run >= req_len);
    end
  end

  always_comb begin
    any_hit = 1'b0;
    sel     = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit[j]) begin
        any_hit = 1'b1;
        sel     = BIT_AW'(j);
      end
    end
  end

  assign sel_start = start_j[sel];
  assign word_hi   = hi_set(d);
  assign next_start = word_hi[BIT_AW] ?
                      CNT_W'({w, word_hi[BIT_AW-1:0]}) + CNT_W'(1) : run_start;

  // Bits of the current mark word that fall inside the allocated run.
  assign mark_lo = (mw == sw) ? sb : '0;
  assign mark_hi = (mw == ew) ? eb : {BIT_AW{1'b1}};
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      mark_mask[b] = (BIT_AW'(b) >= mark_lo) && (BIT_AW'(b) <= mark_hi);
    end
  end

  // Memory port control.
  assign rd_addr = (state == S_SCAN) ? w + WORD_AW'(1) : '0;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = mw;
    wr_mask = mark_mask;
    wr_data = {WORD_W{1'b1}};
    if (state == S_MARK) begin
      wr_en = 1'b1;
    end else if (accept && (in_data.command == CMD_FREE) &&
                 (CNT_W'(in_data.block_index) < cnt)) begin
      wr_en   = 1'b1;
      wr_addr = in_data.block_index[IDX_W-1:BIT_AW];
      wr_mask = WORD_W'(1) << in_data.block_index[BIT_AW-1:0];
      wr_data = '0;
    end
  end

  // A row written for the first time gets all of its bits, the rest cleared.
  assign eff_mask = row_valid[wr_addr] ? wr_mask : {WORD_W{1'b1}};
  assign eff_data = wr_data & wr_mask;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int b = 0; b < WORD_W; b++) begin
        if (eff_mask[b]) mem[wr_addr][b] <= eff_data[b];
      end
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (wr_en) row_valid[wr_addr] <= 1'b1;
      rd_vld <= row_valid[rd_addr];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      block_count  <= BLOCK_COUNT_RESET;
      free_counter <= BLOCK_COUNT_RESET;
    end else begin
      if (cfg_wr) begin
        block_count <= pwdata[CNT_W-1:0];
        if (pwdata[CNT_W-1:0] == '0) begin
          free_counter <= CNT_W'(1);
        end else if (pwdata[CNT_W-1:0] > BLOCK_COUNT_MAX) begin
          free_counter <= BLOCK_COUNT_MAX;
        end else begin
          free_counter <= pwdata[CNT_W-1:0];
        end
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_first <= '0;
            if (in_data.command == CMD_FREE) begin
              state <= S_DONE;
              if (CNT_W'(in_data.block_index) >= cnt) begin
                res_status <= ST_RANGE;
              end else begin
                res_status <= ST_OK;
                if (free_counter < cnt) free_counter <= free_counter + CNT_W'(1);
              end
            end else if (in_data.run_length == '0) begin
              res_status <= ST_ZERO;
              state      <= S_DONE;
            end else begin
              req_len   <= in_data.run_length;
              w         <= '0;
              run_start <= '0;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (any_hit) begin
            res_status   <= ST_OK;
            res_first    <= sel_start[IDX_W-1:0];
            sw           <= sel_start[IDX_W-1:BIT_AW];
            sb           <= sel_start[BIT_AW-1:0];
            mw           <= sel_start[IDX_W-1:BIT_AW];
            ew           <= w;
            eb           <= sel;
            free_counter <= (free_counter >= req_len) ? free_counter - req_len : '0;
            state        <= S_MARK;
          end else if (w == last_word) begin
            res_status <= ST_NOFIT;
            res_first  <= '0;
            state      <= S_DONE;
          end else begin
            w         <= w + WORD_AW'(1);
            run_start <= next_start;
          end
        end
        S_MARK: begin
          if (mw == ew) begin
            state <= S_DONE;
          end else begin
            mw <= mw + WORD_AW'(1);
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: holds a result beat until the far side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_data.status     <= res_status;
      out_data.run_base   <= res_first;
      out_data.free_count <= free_counter;
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for bitmap_contiguous_block_allocator_core: directed table, then random phases.
// Depends on bca_pkg and the core RTL; predicts every reply beat with its own used-map model.
module testbench
  import bca_pkg::*;
();

  // Cycles with no beat on either channel before the run is declared hung. The longest
  // legitimate quiet stretch is the forced receiver hold-off plus one allocate scan.
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int NUM_PHASES    = 10;
  localparam int PHASE_ITEMS   = 130;
  localparam int RANDOM_PHASE  = 7;   // block count drawn at run time
  localparam int HOLD_PHASE    = 0;   // receiver goes deaf for a long stretch
  localparam int PAUSE_PHASE   = 2;   // sender waits for every reply mid-phase
  localparam int QUIET_PHASE   = 4;   // neither side idles
  localparam int DIR_ROWS      = 25;
  localparam int REPORT_MAX    = 10;

  typedef enum logic {ROW_REQ, ROW_WRITE} row_kind_t;

  // One row of the directed table. A request row with typed set carries its reply in
  // st/first/free; otherwise the reply comes from the predictor. A write row programs
  // block_count with wdata once the block has gone idle.
  typedef struct packed {
    row_kind_t        kind;
    logic             cmd;
    logic [CNT_W-1:0] len;
    logic [IDX_W-1:0] idx;
    logic [31:0]      wdata;
    logic             typed;
    logic [1:0]       st;
    logic [IDX_W-1:0] first;
    logic [CNT_W-1:0] free;
  } dir_row_t;

  dir_row_t dir_table [DIR_ROWS] = '{
    // Fresh map, 1024 blocks: zero length, first single block, too long, far too long.
    '{ROW_REQ,   CMD_ALLOC, 11'd0,    10'd1023, 32'd0, 1'b1, ST_ZERO,  10'd0, 11'd1024},
    '{ROW_REQ,   CMD_ALLOC, 11'd1,    10'd0,    32'd0, 1'b1, ST_OK,    10'd0, 11'd1023},
    '{ROW_REQ,   CMD_ALLOC, 11'd1024, 10'd0,    32'd0, 1'b1, ST_NOFIT, 10'd0, 11'd1023},
    '{ROW_REQ,   CMD_ALLOC, 11'd2047, 10'd1023, 32'd0, 1'b1, ST_NOFIT, 10'd0, 11'd1023},
    // Take everything that is left, then find the map full.
    '{ROW_REQ,   CMD_ALLOC, 11'd1023, 10'd0,    32'd0, 1'b1, ST_OK,    10'd1, 11'd0},
    '{ROW_REQ,   CMD_ALLOC, 11'd1,    10'd0,    32'd0, 1'b1, ST_NOFIT, 10'd0, 11'd0},
    // Release the top block, then release it again while already free.
    '{ROW_REQ,   CMD_FREE,  11'd2047, 10'd1023, 32'd0, 1'b1, ST_OK,    10'd0, 11'd1},
    '{ROW_REQ,   CMD_FREE,  11'd0,    10'd1023, 32'd0, 1'b0, ST_OK,    10'd0, 11'd0},
    '{ROW_REQ,   CMD_FREE,  11'd0,    10'd512,  32'd0, 1'b0, ST_OK,    10'd0, 11'd0},
    // Two isolated holes: a pair does not fit, a single lands in the lower hole.
    '{ROW_REQ,   CMD_ALLOC, 11'd2,    10'd0,    32'd0, 1'b0, ST_OK,    10'd0, 11'd0},
    '{ROW_REQ,   CMD_ALLOC, 11'd1,    10'd0,    32'd0, 1'b0, ST_OK,    10'd0, 11'd0},
    // Count of zero with junk upper bits clamps to one block.
    '{ROW_WRITE, CMD_ALLOC, 11'd0, 10'd0, 32'hFFFF_F800, 1'b0, ST_OK,  10'd0, 11'd0},
    '{ROW_REQ,   CMD_FREE,  11'd0,    10'd1,    32'd0, 1'b1, ST_RANGE, 10'd0, 11'd1},
    '{ROW_REQ,   CMD_FREE,  11'd0,    10'd0,    32'd0, 1'b1, ST_OK,    10'd0, 11'd1},
    '{ROW_REQ,   CMD_ALLOC, 11'd1,    10'd0,    32'd0, 1'b1, ST_OK,    10'd0, 11'd0},
    '{ROW_REQ,   CMD_ALLOC, 11'd2,    10'd0,    32'd0, 1'b1, ST_NOFIT, 10'd0, 11'd0},
    // All-ones count clamps to the full map; the counter saturates on a spare release.
    '{ROW_WRITE, CMD_ALLOC, 11'd0, 10'd0, 32'd2047,     1'b0, ST_OK,  10'd0, 11'd0},
    '{ROW_REQ,   CMD_FREE,  11'd0,    10'd1023, 32'd0, 1'b0, ST_OK,    10'd0, 11'd0},
    '{ROW_REQ,   CMD_ALLOC, 11'd1,    10'd0,    32'd0, 1'b0, ST_OK,    10'd0, 11'd0},
    // Eight blocks: indexes at and far above the count are out of range.
    '{ROW_WRITE, CMD_ALLOC, 11'd0, 10'd0, 32'd8,        1'b0, ST_OK,  10'd0, 11'd0},
    '{ROW_REQ,   CMD_FREE,  11'd0,    10'd8,    32'd0, 1'b1, ST_RANGE, 10'd0, 11'd8},
    '{ROW_REQ,   CMD_FREE,  11'd0,    10'd1023, 32'd0, 1'b1, ST_RANGE, 10'd0, 11'd8},
    '{ROW_REQ,   CMD_FREE,  11'd0,    10'd7,    32'd0, 1'b0, ST_OK,    10'd0, 11'd0},
    '{ROW_REQ,   CMD_ALLOC, 11'd8,    10'd0,    32'd0, 1'b0, ST_OK,    10'd0, 11'd0},
    '{ROW_WRITE, CMD_ALLOC, 11'd0, 10'd0, 32'd1024,     1'b0, ST_OK,  10'd0, 11'd0}
  };

  // Block counts for the random phases; the extremes 0 and 2047 both clamp.
  logic [31:0] phase_counts [NUM_PHASES] = '{1024, 16, 1, 2047, 64, 0, 1025, 0, 300, 1024};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  alloc_req_t         in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  alloc_rsp_t         out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Typed reply that rides along with the request beat for directed rows.
  logic       typed_check = 1'b0;
  alloc_rsp_t typed_reply = '0;

  // Predictor state: the used map, the programmed count and the free counter.
  logic             used_blk [NUM_BLOCKS] = '{default: 1'b0};
  logic [CNT_W-1:0] blk_count_reg = BLOCK_COUNT_RESET;
  logic [CNT_W-1:0] free_ctr = BLOCK_COUNT_RESET;

  alloc_rsp_t replies_due [$];
  int         bad_replies = 0;
  int         bad_readbacks = 0;
  int         quiet_cycles = 0;
  bit         sender_gaps = 1'b1;
  bit         receiver_gaps = 1'b1;
  bit         long_hold = 1'b0;

  bitmap_contiguous_block_allocator_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // The programmed count is clamped to 1..NUM_BLOCKS wherever it is used.
  function automatic int unsigned live_count();
    if (blk_count_reg == 0) return 1;
    if (blk_count_reg > NUM_BLOCKS) return NUM_BLOCKS;
    return 32'(blk_count_reg);
  endfunction

  // Applies one request to the predicted map and counter and returns its reply.
  // Allocation is first fit: the lowest run of free blocks long enough wins.
  function automatic alloc_rsp_t allocate_or_release(alloc_req_t r);
    int unsigned cnt, run, start, k;
    alloc_rsp_t  res;
    cnt = live_count();
    res = '0;
    res.status = ST_OK;
    if (r.command == CMD_ALLOC) begin
      if (r.run_length == 0) begin
        res.status = ST_ZERO;
      end else begin
        run = 0;
        start = 0;
        k = 0;
        while (k < cnt && run < r.run_length) begin
          if (used_blk[k]) begin
            run = 0;
          end else begin
            if (run == 0) start = k;
            run++;
          end
          k++;
        end
        if (run < r.run_length) begin
          res.status = ST_NOFIT;
        end else begin
          for (k = start; k < start + r.run_length; k++) used_blk[k] = 1'b1;
          free_ctr = (free_ctr >= r.run_length) ? free_ctr - r.run_length : '0;
          res.run_base = IDX_W'(start);
        end
      end
    end else begin
      if (r.block_index >= cnt) begin
        res.status = ST_RANGE;
      end else begin
        used_blk[r.block_index] = 1'b0;
        if (free_ctr < cnt) free_ctr++;
      end
    end
    res.free_count = free_ctr;
    return res;
  endfunction

  // Random request biased toward short runs and toward releasing blocks that are in use,
  // with a share of zero lengths, oversized runs and out-of-range indexes.
  function automatic alloc_req_t pick_request();
    alloc_req_t  r;
    int unsigned cnt, roll, k, step;
    cnt = live_count();
    roll = $urandom_range(0, 99);
    r.command = ($urandom_range(0, 99) < 50) ? CMD_ALLOC : CMD_FREE;
    r.run_length = CNT_W'($urandom_range(0, 2047));
    r.block_index = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
    if (r.command == CMD_ALLOC) begin
      if (roll < 5) r.run_length = '0;
      else if (roll < 10) r.run_length = CNT_W'($urandom_range(cnt, 2047));
      else if (roll < 75) r.run_length = CNT_W'($urandom_range(1, (cnt < 8) ? cnt : 8));
      else r.run_length = CNT_W'($urandom_range(1, cnt));
    end else if (roll < 75) begin
      // Walk forward from a random spot to the next used block; a full-free map
      // leaves the starting spot.
      k = $urandom_range(0, cnt - 1);
      for (step = 0; step < cnt; step++)
        if (used_blk[(k + step) % cnt]) break;
      r.block_index = IDX_W'((k + step) % cnt);
    end else if (roll < 90 && cnt < NUM_BLOCKS) begin
      r.block_index = IDX_W'($urandom_range(cnt, NUM_BLOCKS - 1));
    end
    return r;
  endfunction

  // Offers one request beat and returns at the edge where it is taken. Valid stays high
  // on return so that back-to-back beats need no dead cycle.
  task automatic send_beat(input alloc_req_t r, input logic typed, input alloc_rsp_t reply);
    while (sender_gaps && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    typed_check <= typed;
    typed_reply <= reply;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering and waits until every reply beat owed has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register access: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {REG_BLOCK_COUNT, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes block_count and reads it back; the scoreboard sees the write beat and
  // reloads the predicted free counter. Only called with the block idle.
  task automatic program_block_count(input logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b1, value, rd);
    apb_access(1'b0, '0, rd);
    if (rd[CNT_W-1:0] !== value[CNT_W-1:0]) begin
      bad_readbacks++;
      if (bad_readbacks <= REPORT_MAX)
        $display("block_count readback: expected %0d, got %0d", value[CNT_W-1:0],
                 rd[CNT_W-1:0]);
    end
  endtask

  // Receiver: random stalls, or a counted hold-off when the stimulus asks for one so
  // that the core fills its output register and pushes back on the request side.
  initial begin : receiver
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= receiver_gaps && ($urandom_range(0, 99) < 15);
      end
    end
  end

  // Both channels are sampled on the rising edge, before this edge's updates land. A
  // request beat runs through the predictor at once; a reply beat is checked against
  // the oldest reply owed. A block_count write reloads the predicted counter.
  always @(posedge clk) begin : scoreboard
    alloc_rsp_t predicted, want;
    if (!rst) begin
      if (psel && penable && pwrite && pready && (paddr[2] == REG_BLOCK_COUNT)) begin
        blk_count_reg = pwdata[CNT_W-1:0];
        free_ctr = CNT_W'(live_count());
      end
      if (in_valid && !in_stall) begin
        predicted = allocate_or_release(in_data);
        replies_due.push_back(typed_check ? typed_reply : predicted);
      end
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          bad_replies++;
          if (bad_replies <= REPORT_MAX)
            $display("reply beat with nothing owed: status %0d first %0d free %0d",
                     out_data.status, out_data.run_base, out_data.free_count);
        end else begin
          want = replies_due.pop_front();
          if (out_data.status !== want.status || out_data.run_base !== want.run_base
              || out_data.free_count !== want.free_count) begin
            bad_replies++;
            if (bad_replies <= REPORT_MAX)
              $display("reply mismatch: expected status %0d first %0d free %0d, got %0d %0d %0d",
                       want.status, want.run_base, want.free_count,
                       out_data.status, out_data.run_base, out_data.free_count);
          end
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no beat on either channel means the core hung.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("bitmap_contiguous_block_allocator_core verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t    row;
    alloc_req_t  req;
    alloc_rsp_t  reply;
    int unsigned cnt, start, stretch, k;
    int          n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part: extremes, every code and the clamping and saturation corners.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_table[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        program_block_count(row.wdata);
      end else begin
        req = '{command: row.cmd, run_length: row.len, block_index: row.idx};
        reply = '{status: row.st, run_base: row.first, free_count: row.free};
        send_beat(req, row.typed, reply);
      end
    end

    // Random part: one block count per phase, with the map carried across phases.
    phase_counts[RANDOM_PHASE] = $urandom_range(2, NUM_BLOCKS);
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      program_block_count(phase_counts[p]);
      sender_gaps = (p != QUIET_PHASE);
      receiver_gaps = (p != QUIET_PHASE);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if (p == HOLD_PHASE && n == 40) long_hold = 1'b1;
        if (p == PAUSE_PHASE && n == 60) settle();
        if ($urandom_range(0, 99) < 8) begin
          // Release a contiguous stretch so that longer runs fit again later.
          cnt = live_count();
          start = $urandom_range(0, cnt - 1);
          stretch = $urandom_range(1, 16);
          for (k = 0; k < stretch && n < PHASE_ITEMS; k++) begin
            req.command = CMD_FREE;
            req.run_length = CNT_W'($urandom_range(0, 2047));
            req.block_index = IDX_W'(start + k);
            send_beat(req, 1'b0, '0);
            n++;
          end
        end else begin
          send_beat(pick_request(), 1'b0, '0);
          n++;
        end
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_replies == 0 && bad_readbacks == 0 && replies_due.size() == 0) begin
      $display("bitmap_contiguous_block_allocator_core verification clean");
    end else begin
      $display("bitmap_contiguous_block_allocator_core verification failed");
    end
    $finish;
  end

endmodule
